// File: design/b2da_pkg.sv
// Shared types and constants for the binary to decimal ASCII converter.
// Depends on nothing; every other design file refers to it by scoped names.
package b2da_pkg;

	localparam int VALUE_W        = 31;
	localparam int MIN_W          = 5;
	localparam int CHAR_W         = 6;
	localparam int COUNT_W        = 5;
	// decimal digits needed for the largest 31-bit value
	localparam int BCD_DIGITS     = 10;
	localparam int BCD_IDX_W      = $clog2(BCD_DIGITS);
	localparam int SHIFT_CNT_W    = $clog2(VALUE_W);
	localparam int MAX_DIGITS_DEF = 16;
	localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic [MIN_W-1:0]   min_digits;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0]  ascii_char;
		logic [COUNT_W-1:0] digit_count;
		logic               last_char;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic shift;
		logic size;
		logic emit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic slot_free;
		logic pos_zero;
	} sts_t;

endpackage

// File: design/b2da_ctrl.sv
// Sequencer for the converter: idle, shift-add conversion, sizing, digit emission.
// Depends on b2da_pkg for the command and status structs.
module b2da_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  b2da_pkg::sts_t sts,
	output b2da_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CONV = 2'd1;
	localparam logic [1:0] ST_SIZE = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;
	localparam logic [b2da_pkg::SHIFT_CNT_W-1:0] LAST_SHIFT =
		b2da_pkg::SHIFT_CNT_W'(b2da_pkg::VALUE_W - 1);

	logic [1:0]                         state_q;
	logic [b2da_pkg::SHIFT_CNT_W-1:0]   shift_cnt_q;

	assign req_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd       = '0;
		cmd.load  = (state_q == ST_IDLE) && req_valid;
		cmd.shift = (state_q == ST_CONV);
		cmd.size  = (state_q == ST_SIZE);
		cmd.emit  = (state_q == ST_EMIT) && sts.slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			shift_cnt_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					shift_cnt_q <= '0;
					if (req_valid) begin
						state_q <= ST_CONV;
					end
				end
				ST_CONV: begin
					shift_cnt_q <= shift_cnt_q + 1'b1;
					if (shift_cnt_q == LAST_SHIFT) begin
						state_q <= ST_SIZE;
					end
				end
				ST_SIZE: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// leave once the final digit is in the output register
					if (cmd.emit && sts.pos_zero) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/b2da_dp.sv
// Datapath: binary and BCD shift registers, digit count and the output register.
// Depends on b2da_pkg; driven by commands from b2da_ctrl.
module b2da_dp #(
	parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  b2da_pkg::in_item_t  req_item,
	input  b2da_pkg::cmd_t      cmd,
	output b2da_pkg::sts_t      sts,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output b2da_pkg::out_item_t rsp_item
);

	localparam int CW = $clog2(MAX_DIGITS + 1);

	logic [b2da_pkg::VALUE_W-1:0] bin_q;
	logic [3:0]                   bcd_q [b2da_pkg::BCD_DIGITS];
	logic [3:0]                   bcd_adj [b2da_pkg::BCD_DIGITS];
	logic [CW-1:0]                min_q;
	logic [CW-1:0]                min_sat;
	logic [CW-1:0]                total_q;
	logic [CW-1:0]                pos_q;
	logic [CW-1:0]                sig_n;
	logic [CW-1:0]                total_d;
	logic [3:0]                   cur_digit;
	logic                         rsp_valid_q;
	b2da_pkg::out_item_t          rsp_item_q;

	always_comb begin
		if (int'(req_item.min_digits) > MAX_DIGITS) begin
			min_sat = CW'(MAX_DIGITS);
		end else begin
			min_sat = CW'(req_item.min_digits);
		end
	end

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int k = 0; k < b2da_pkg::BCD_DIGITS; k++) begin
			bcd_adj[k] = (bcd_q[k] >= 4'd5) ? bcd_q[k] + 4'd3 : bcd_q[k];
		end
	end

	// significant digits: one above the highest non-zero digit
	always_comb begin
		sig_n = '0;
		for (int k = 0; k < b2da_pkg::BCD_DIGITS; k++) begin
			if (bcd_q[k] != 4'd0) begin
				sig_n = CW'(k + 1);
			end
		end
		total_d = (sig_n > min_q) ? sig_n : min_q;
		if (total_d == '0) begin
			total_d = CW'(1);
		end
	end

	always_comb begin
		if (int'(pos_q) < b2da_pkg::BCD_DIGITS) begin
			cur_digit = bcd_q[pos_q[b2da_pkg::BCD_IDX_W-1:0]];
		end else begin
			cur_digit = 4'd0;
		end
	end

	assign sts.slot_free = !rsp_valid_q || !rsp_stall;
	assign sts.pos_zero  = (pos_q == '0);
	assign rsp_valid     = rsp_valid_q;
	assign rsp_item      = rsp_item_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bin_q <= req_item.value;
			min_q <= min_sat;
			for (int k = 0; k < b2da_pkg::BCD_DIGITS; k++) begin
				bcd_q[k] <= 4'd0;
			end
		end else if (cmd.shift) begin
			bin_q    <= {bin_q[b2da_pkg::VALUE_W-2:0], 1'b0};
			bcd_q[0] <= {bcd_adj[0][2:0], bin_q[b2da_pkg::VALUE_W-1]};
			for (int k = 1; k < b2da_pkg::BCD_DIGITS; k++) begin
				bcd_q[k] <= {bcd_adj[k][2:0], bcd_adj[k-1][3]};
			end
		end
		if (cmd.size) begin
			total_q <= total_d;
			pos_q   <= total_d - 1'b1;
		end else if (cmd.emit) begin
			pos_q <= pos_q - 1'b1;
		end
		if (cmd.emit) begin
			rsp_item_q.ascii_char  <= b2da_pkg::ASCII_ZERO + {2'b00, cur_digit};
			rsp_item_q.digit_count <= b2da_pkg::COUNT_W'(total_q);
			rsp_item_q.last_char   <= (pos_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

endmodule

// File: design/binary_to_decimal_ascii.sv
// Binary to decimal ASCII converter. After an input transfer the item runs through the
// 31-step shift-add conversion loop and a sizing step before its first digit enters
// the output register; then one digit a cycle unless stalled. A new item is taken only
// once the last digit of the previous run is in the single output register.
// Reset (arst_n low, asynchronous): sequencer idle, output register empty.
module binary_to_decimal_ascii #(
	parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  b2da_pkg::in_item_t  req_item,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output b2da_pkg::out_item_t rsp_item
);

	b2da_pkg::cmd_t cmd;
	b2da_pkg::sts_t sts;

	// Sequencer: takes one item in idle, runs the conversion, sizes the run,
	// then steps the digits out most significant first.
	b2da_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: double-dabble registers, digit count and output register. The
	// output register decouples the sides, so a new item may transfer while the
	// final digit of the previous run still waits downstream.
	b2da_dp #(
		.MAX_DIGITS (MAX_DIGITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_item  (req_item),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item)
	);

	// Hold off further input once an item has transferred.
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("input taken while a run is in progress");

	// Every emitted character must be a decimal digit.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_item.ascii_char >= 6'd48) && (rsp_item.ascii_char <= 6'd57))
		else $error("non-digit character emitted");

	// A waiting digit that is not the last implies its run is still active.
	a_run_active: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_item.last_char |-> req_stall)
		else $error("sequencer idle with a run unfinished");

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for binary_to_decimal_ascii: directed table, then random items.
// Depends on b2da_pkg for the item types and on the design top level alone.
module testbench;

	import b2da_pkg::*;

	localparam int MAX_DIGITS = MAX_DIGITS_DEF;
	localparam int DIR_N      = 18;
	localparam int RAND_N     = 330;
	localparam int PAUSE_AT   = 150;   // random item after which the sender drains
	localparam int HOLD_AFTER = 600;   // digits seen before the long receiver hold
	localparam int HOLD_LEN   = 400;
	localparam int IDLE_LIMIT = 3000;  // cycles with no transfer before giving up
	localparam int TAIL       = 40;
	localparam int MAX_SHOWN  = 10;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	in_item_t  req_item = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	out_item_t rsp_item;

	out_item_t pending_digits [$];
	int        fail_count = 0;
	int        digits_seen = 0;
	int        idle_cycles = 0;

	// Directed table. An empty text means the row is checked against the predictor;
	// otherwise the text is the digit string expected, most significant first.
	logic [VALUE_W-1:0] dir_value [DIR_N] = '{
		31'd0, 31'd0, 31'd0, 31'd0,
		31'd2147483647, 31'd2147483647, 31'd2147483647,
		31'd1, 31'd9, 31'd10, 31'd999999999, 31'd1000000000,
		31'd12345, 31'd12345,
		31'd1431655765, 31'd715827882, 31'd1073741824, 31'd7
	};
	logic [MIN_W-1:0] dir_min [DIR_N] = '{
		5'd0, 5'd1, 5'd16, 5'd31,
		5'd0, 5'd16, 5'd17,
		5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
		5'd8, 5'd3,
		5'd10, 5'd21, 5'd15, 5'd16
	};
	string dir_text [DIR_N] = '{
		"0", "0", "0000000000000000", "0000000000000000",
		"2147483647", "0000002147483647", "0000002147483647",
		"1", "9", "10", "999999999", "1000000000",
		"00012345", "12345",
		"", "", "", "0000000000000007"
	};

	binary_to_decimal_ascii #(
		.MAX_DIGITS(MAX_DIGITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_item (req_item),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_item (rsp_item)
	);

	always #5 clk = ~clk;

	// Work out the decimal digits of one item, most significant first, and queue
	// them. The minimum count saturates at MAX_DIGITS; zero with no minimum still
	// gives a single '0'.
	function automatic void push_decimal_digits(in_item_t it);
		logic [3:0]         low_first [MAX_DIGITS];
		logic [VALUE_W-1:0] rest;
		int                 n;
		int                 total;
		int                 floor_cnt;
		logic [3:0]         digit;
		out_item_t          d;
		rest = it.value;
		floor_cnt = int'(it.min_digits);
		n = 0;
		if (floor_cnt > MAX_DIGITS)
			floor_cnt = MAX_DIGITS;
		while (rest != 0 && n < MAX_DIGITS) begin
			low_first[n] = 4'(rest % 10);
			rest = VALUE_W'(rest / 10);
			n++;
		end
		total = (n > floor_cnt) ? n : floor_cnt;
		if (total == 0)
			total = 1;
		for (int i = 0; i < total; i++) begin
			// padding positions above the significant digits read as zero
			digit = (total - 1 - i < n) ? low_first[total - 1 - i] : 4'd0;
			d.ascii_char  = ASCII_ZERO + CHAR_W'(digit);
			d.digit_count = COUNT_W'(total);
			d.last_char   = (i == total - 1);
			pending_digits.push_back(d);
		end
	endfunction

	// Queue a digit string typed into the table.
	function automatic void push_text_digits(string txt);
		out_item_t d;
		for (int i = 0; i < txt.len(); i++) begin
			d.ascii_char  = CHAR_W'(txt[i]);
			d.digit_count = COUNT_W'(txt.len());
			d.last_char   = (i == txt.len() - 1);
			pending_digits.push_back(d);
		end
	endfunction

	// Values of every magnitude: shift a random word right so that short numbers
	// and zeros turn up often; the minimum mostly stays in range, some saturate.
	function automatic in_item_t random_item();
		in_item_t it;
		int       r;
		r = $urandom_range(0, 99);
		it.value = VALUE_W'($urandom() >> $urandom_range(0, 31));
		if (r < 6)
			it.value = '0;
		r = $urandom_range(0, 99);
		if (r < 20)
			it.min_digits = '0;
		else if (r < 85)
			it.min_digits = MIN_W'($urandom_range(1, MAX_DIGITS));
		else
			it.min_digits = MIN_W'($urandom_range(MAX_DIGITS + 1, 31));
		return it;
	endfunction

	// Mostly short gaps, now and then a long one; none at all in quiet stretches.
	function automatic int sender_gap(int k);
		int r;
		if ((k / 40) % 4 == 1)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(30, 120);
	endfunction

	// Offer one item and hold it until the block takes it. Expectations are
	// queued at the accepting edge, well before the first digit can appear.
	task automatic offer(input in_item_t it, input string txt);
		req_item  <= it;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		if (txt.len() != 0)
			push_text_digits(txt);
		else
			push_decimal_digits(it);
	endtask

	// Drop valid for a while; a gap of zero keeps it high into the next item.
	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			req_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// Sender: reset, the directed table, then random items.
	initial begin : sender
		in_item_t it;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		for (int k = 0; k < DIR_N; k++) begin
			it.value      = dir_value[k];
			it.min_digits = dir_min[k];
			offer(it, dir_text[k]);
			pause_sender(sender_gap(k));
		end

		for (int k = 0; k < RAND_N; k++) begin
			offer(random_item(), "");
			if (k == PAUSE_AT) begin
				// hold back until every digit owed so far has come out
				req_valid <= 1'b0;
				@(posedge clk);
				while (pending_digits.size() != 0)
					@(posedge clk);
			end else begin
				pause_sender(sender_gap(k));
			end
		end
		req_valid <= 1'b0;

		// drain, then give the block time to show any stray digit
		while (pending_digits.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// Receiver: random stalls, quiet stretches, and once a long hold while the
	// sender keeps offering, so the block backs up and stalls its input.
	initial begin : receiver
		bit long_done;
		int r;
		long_done = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!long_done && digits_seen >= HOLD_AFTER) begin
				long_done = 1'b1;
				rsp_stall <= 1'b1;
				repeat (HOLD_LEN) @(posedge clk);
			end else if ((digits_seen / 100) % 4 == 2) begin
				rsp_stall <= 1'b0;
				@(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					rsp_stall <= 1'b0;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end else if (r < 95) begin
					rsp_stall <= 1'b1;
					repeat ($urandom_range(1, 3)) @(posedge clk);
				end else begin
					rsp_stall <= 1'b1;
					repeat ($urandom_range(20, 80)) @(posedge clk);
				end
			end
		end
	end

	// Compare every digit transfer with the oldest expectation.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			digits_seen++;
			if (pending_digits.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_SHOWN)
					$display("%0t: unexpected digit char=%0d count=%0d last=%0b", $realtime,
						rsp_item.ascii_char, rsp_item.digit_count, rsp_item.last_char);
			end else begin
				want = pending_digits.pop_front();
				if (rsp_item.ascii_char !== want.ascii_char
						|| rsp_item.digit_count !== want.digit_count
						|| rsp_item.last_char !== want.last_char) begin
					fail_count++;
					if (fail_count <= MAX_SHOWN) begin
						$display("%0t: digit mismatch: expected char=%0d count=%0d last=%0b",
							$realtime, want.ascii_char, want.digit_count, want.last_char);
						$display("    got char=%0d count=%0d last=%0b",
							rsp_item.ascii_char, rsp_item.digit_count, rsp_item.last_char);
					end
				end
			end
		end
	end

	// Watchdog: count cycles in which neither side transfers anything.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $realtime, IDLE_LIMIT);
			$display("Test completed with failures");
			$finish;
		end
	end

endmodule
